/* src/mexp_pkg.sv */
package mexp_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int IDX_W  = 8;

  // default key width
  localparam int KEY_BITS_DEF = 32;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODULUS  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_EXPONENT = IDX_W'(1);

endpackage

/* src/modular_exponentiation.sv */
// channel  | signals                              | dir | notes
// ---------+--------------------------------------+-----+------------------------------
// in       | in_valid, in_ready, ciphertext       | in  | one ciphertext word per item
// out      | out_valid, out_ready, plaintext      | out | ciphertext^exponent mod modulus
// cfg      | cfg_valid, cfg_ready, cfg_index/data | in  | 0: modulus, 1: exponent
//
// sequence: the ciphertext is first reduced in the shared multiplier, then each
//   scanned exponent bit passes the start state, a serial multiply over the 32 bits
//   of b (double-reduce and add-reduce per bit) and done; the scan stops after
//   the highest set exponent bit
// exponent zero or modulus zero skip the multipliers and go straight to the output state
// reset: synchronous, modulus and exponent both return to 1
// stalls: one item at a time; a finished result waits in the output register;
//   cfg writes are taken only while idle and hold off a new item
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input item
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] ciphertext,
  // result item
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] plaintext,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam int W = KEY_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_SQ_START,
    S_SQ_WAIT,
    S_OUT
  } state_t;

  state_t state;

  // key registers
  logic [W-1:0] modulus;
  logic [W-1:0] exponent;

  // working registers
  logic [W-1:0] base;   // ciphertext^(2^i) mod modulus
  logic [W-1:0] acc;    // running product
  logic [W-1:0] ebits;  // exponent bits not yet scanned, lsb next

  logic in_accept;
  logic normal;         // exponent and modulus both nonzero

  // shared multiplier: base reduction first, then acc * base
  logic              mul_start;
  logic              mul_done;
  logic [W-1:0]      mul_r;
  logic [DATA_W-1:0] mul_b;

  // squaring unit
  logic              sq_start;
  logic              sq_done;
  logic [W-1:0]      sq_r;

  // a pending key write goes first, so an item never sees half a key
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign normal    = (exponent != '0) && (modulus != '0);

  // reduction is ciphertext * 1 mod modulus, scanning all ciphertext bits
  assign mul_start = (in_accept && normal) || (state == S_SQ_START && ebits[0]);
  assign mul_b     = (state == S_IDLE) ? ciphertext : DATA_W'(base);
  assign sq_start  = (state == S_SQ_START);

  mexp_mulmod #(
    .W   (W),
    .B_W (DATA_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (acc),
    .b     (mul_b),
    .m     (modulus),
    .done  (mul_done),
    .r     (mul_r)
  );

  // same scan length as the multiplier, so both finish on the same cycle
  mexp_mulmod #(
    .W   (W),
    .B_W (DATA_W)
  ) u_sq (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .a     (base),
    .b     (DATA_W'(base)),
    .m     (modulus),
    .done  (sq_done),
    .r     (sq_r)
  );

  // configuration writes, taken only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= W'(1);
      exponent <= W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:  modulus  <= cfg_data[W-1:0];
        REG_EXPONENT: exponent <= cfg_data[W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result register loads from the sequencer, clears once taken
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            ebits <= exponent;
            if (exponent == '0) begin
              // zero exponent gives 1, left unreduced
              acc   <= W'(1);
              state <= S_OUT;
            end else if (modulus == '0) begin
              acc   <= '0;
              state <= S_OUT;
            end else begin
              acc   <= W'(1);
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mul_done) begin
            base  <= mul_r;
            state <= S_SQ_START;
          end
        end
        S_SQ_START: begin
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          // both units run the same length, so they finish together
          if (sq_done) begin
            base <= sq_r;
            if (ebits[0]) begin
              acc <= mul_r;
            end
            ebits <= ebits >> 1;
            if (ebits[W-1:1] == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_SQ_START;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            plaintext <= DATA_W'(acc);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // multiply finishing in the loop must line up with the square
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ_WAIT && mul_done) |-> sq_done)
    else $error("multiply done without square done");

  // squared base always stays reduced
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ_WAIT && sq_done) |-> (sq_r < modulus))
    else $error("square result not reduced");

  // an accepted item always leaves idle
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != S_IDLE))
    else $error("item accepted but sequencer stayed idle");

endmodule

/* src/mexp_mulmod.sv */
// bit-serial interleaved modular multiplier: r = a * b mod m
// b is scanned msb first, each bit by a double-reduce step and then an add-reduce step
module mexp_mulmod #(
  parameter int W   = 32,
  parameter int B_W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [B_W-1:0] b,
  input  logic [W-1:0]   m,
  output logic           done,
  output logic [W-1:0]   r
);

  localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

  logic             busy;
  logic             phase;
  logic [CNT_W-1:0] cnt;
  logic [B_W-1:0]   bsh;

  logic [W:0]       t;
  logic [W+1:0]     diff;
  logic [W-1:0]     r_next;

  // one add and one conditional subtract per cycle
  always_comb begin
    if (phase) begin
      t = {1'b0, r} + (bsh[B_W-1] ? {1'b0, a} : '0);
    end else begin
      t = {r, 1'b0};
    end
    diff   = {1'b0, t} - {2'b00, m};
    r_next = diff[W+1] ? t[W-1:0] : diff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
        r     <= '0;
        bsh   <= b;
      end else if (busy) begin
        r     <= r_next;
        phase <= ~phase;
        if (phase) begin
          bsh <= bsh << 1;
          if (cnt == LAST) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
      end
    end
  end

endmodule
